FILE: rtl/roulette_wheel_selector_unit_macros.svh
// Assertion helpers shared by the RTL.
// Both forms sample on the rising edge of clk and are off while arst_n is low.
`ifndef ROULETTE_WHEEL_SELECTOR_UNIT_MACROS_SVH
`define ROULETTE_WHEEL_SELECTOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define RWS_ASSERT_SAME(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("rws assertion failed");
// Next-cycle implication.
`define RWS_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("rws assertion failed");
`else
`define RWS_ASSERT_SAME(label, pre, post)
`define RWS_ASSERT_NEXT(label, pre, post)
`endif

`endif

FILE: rtl/rws_pkg.sv
`timescale 1ns / 1ps
package rws_pkg;

	localparam int MAX_POPULATION = 256;
	localparam int FITNESS_BITS   = 16;
	localparam int RANDOM_BITS    = 16;

	localparam int IDX_BITS    = $clog2(MAX_POPULATION);
	localparam int CNT_BITS    = $clog2(MAX_POPULATION + 1);
	localparam int PREFIX_BITS = FITNESS_BITS + IDX_BITS;
	localparam int PROD_BITS   = PREFIX_BITS + RANDOM_BITS;
	// round tag stored per mark; tag 0 means never chosen
	localparam int EPOCH_BITS  = 8;

	localparam int IN_TDATA_BITS  = 32;
	localparam int OUT_TDATA_BITS = 16;
	localparam int CMD_BITS       = 2;
	localparam int ERR_BITS       = 3;

	localparam int CFG_ADDR_BITS = 3;
	localparam int CFG_DATA_BITS = 32;
	// register index, taken from paddr[2]
	localparam logic REG_PARENTS_WANTED = 1'b0;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_LOAD      = 2'd0,
		CMD_DRAW      = 2'd1,
		CMD_NEW_ROUND = 2'd2,
		CMD_CLEAR     = 2'd3
	} cmd_t;

	typedef enum logic [ERR_BITS-1:0] {
		ERR_OK     = 3'd0,
		ERR_EMPTY  = 3'd1,
		ERR_WANTED = 3'd2,
		ERR_ZERO   = 3'd3,
		ERR_DONE   = 3'd4
	} err_t;

	typedef struct packed {
		logic                done;
		logic [IDX_BITS-1:0] idx;
	} srch_stat_t;

endpackage

FILE: rtl/rws_ram.sv
`timescale 1ns / 1ps
module rws_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/rws_search.sv
`timescale 1ns / 1ps
module rws_search (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [rws_pkg::IDX_BITS-1:0]       last_idx,
	input  logic [rws_pkg::PREFIX_BITS-1:0]    target,
	input  logic [rws_pkg::PREFIX_BITS-1:0]    rd_data,
	output logic [rws_pkg::IDX_BITS-1:0]       rd_addr,
	output rws_pkg::srch_stat_t                stat
);

	typedef enum logic [1:0] {
		SR_IDLE,
		SR_READ,
		SR_CMP
	} phase_t;

	phase_t                         phase_q;
	logic [rws_pkg::IDX_BITS-1:0]   lo_q;
	logic [rws_pkg::IDX_BITS-1:0]   hi_q;
	logic [rws_pkg::IDX_BITS-1:0]   mid_q;
	logic [rws_pkg::IDX_BITS-1:0]   mid;
	logic                           open;

	assign mid     = lo_q + ((hi_q - lo_q) >> 1);
	assign open    = lo_q < hi_q;
	assign rd_addr = mid;

	assign stat.done = (phase_q == SR_READ) && !open;
	assign stat.idx  = lo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= SR_IDLE;
		end else begin
			case (phase_q)
				SR_IDLE: begin
					if (start) begin
						phase_q <= SR_READ;
					end
				end
				SR_READ: begin
					phase_q <= open ? SR_CMP : SR_IDLE;
				end
				SR_CMP: begin
					phase_q <= SR_READ;
				end
				default: begin
					phase_q <= SR_IDLE;
				end
			endcase
		end
	end

	// bounds narrow to the first entry whose prefix reaches the target
	always_ff @(posedge clk) begin
		case (phase_q)
			SR_IDLE: begin
				if (start) begin
					lo_q <= '0;
					hi_q <= last_idx;
				end
			end
			SR_READ: begin
				mid_q <= mid;
			end
			SR_CMP: begin
				if (rd_data >= target) begin
					hi_q <= mid_q;
				end else begin
					lo_q <= mid_q + rws_pkg::IDX_BITS'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/roulette_wheel_selector_unit.sv
// Roulette wheel selector. Load beats append one fitness value each and store the running
// prefix sum; a draw beat scales its random fraction by the total with one multiply, then
// binary-searches the prefix RAM for the first entry at or above that target, each halving
// step a RAM read then a compare, and marks the hit. A draw that ends in an error skips the
// search. Chosen marks sit in a RAM as round tags, so a new round only bumps the tag; after
// reset, and on every 255th new round or clear when the tag wraps, the block zeroes every
// entry of that RAM and takes no beat. The block takes no new beat while a draw is in
// flight, but it does take beats while a finished result waits on m_*.
`timescale 1ns / 1ps
`include "roulette_wheel_selector_unit_macros.svh"
module roulette_wheel_selector_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [15:0] fitness_value, [31:16] random_fraction
	input  logic [rws_pkg::IN_TDATA_BITS-1:0]   s_tdata,
	// [1:0] command
	input  logic [rws_pkg::CMD_BITS-1:0]        s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [7:0] selected_index, [8] newly_chosen, [9] round_done, [12:10] error_code, rest zero
	output logic [rws_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rws_pkg::CFG_ADDR_BITS-1:0]   paddr,
	input  logic [rws_pkg::CFG_DATA_BITS-1:0]   pwdata,
	output logic [rws_pkg::CFG_DATA_BITS-1:0]   prdata,
	output logic                                pready
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SEARCH,
		ST_MARK,
		ST_EMIT,
		ST_WIPE
	} state_t;

	state_t                                 state_q;
	logic [rws_pkg::CNT_BITS-1:0]           pw_q;
	logic [rws_pkg::CNT_BITS-1:0]           lc_q;
	logic [rws_pkg::CNT_BITS-1:0]           cc_q;
	logic [rws_pkg::PREFIX_BITS-1:0]        total_q;
	logic [rws_pkg::EPOCH_BITS-1:0]         epoch_q;
	logic [rws_pkg::IDX_BITS-1:0]           wipe_q;
	logic [rws_pkg::RANDOM_BITS-1:0]        r_q;
	logic [rws_pkg::PREFIX_BITS-1:0]        target_q;
	logic [rws_pkg::IDX_BITS-1:0]           idx_q;
	logic                                   fresh_q;
	logic                                   done_q;
	rws_pkg::err_t                          err_q;
	logic                                   m_tvalid_q;
	logic [rws_pkg::IDX_BITS-1:0]           out_idx_q;
	logic                                   out_fresh_q;
	logic                                   out_done_q;
	rws_pkg::err_t                          out_err_q;

	logic                                   in_acc;
	rws_pkg::cmd_t                          cmd;
	logic [rws_pkg::FITNESS_BITS-1:0]       fit;
	logic [rws_pkg::RANDOM_BITS-1:0]        rnd;
	logic                                   full;
	logic                                   load_we;
	logic [rws_pkg::PREFIX_BITS-1:0]        prefix_base;
	logic [rws_pkg::PREFIX_BITS-1:0]        prefix_new;
	rws_pkg::err_t                          draw_err;
	logic [rws_pkg::PROD_BITS-1:0]          prod;
	logic                                   fresh;
	logic [rws_pkg::CNT_BITS-1:0]           cc_next;
	logic                                   out_free;
	logic                                   epoch_wrap;
	logic                                   cfg_we;
	logic                                   srch_start;
	logic [rws_pkg::IDX_BITS-1:0]           last_idx;
	logic [rws_pkg::IDX_BITS-1:0]           srch_addr;
	logic [rws_pkg::IDX_BITS-1:0]           ram_addr;
	logic [rws_pkg::PREFIX_BITS-1:0]        ram_rdata;
	rws_pkg::srch_stat_t                    srch_stat;
	logic                                   mark_we;
	logic [rws_pkg::IDX_BITS-1:0]           mark_addr;
	logic [rws_pkg::EPOCH_BITS-1:0]         mark_wdata;
	logic [rws_pkg::EPOCH_BITS-1:0]         mark_rdata;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign cmd      = rws_pkg::cmd_t'(s_tuser);
	assign fit      = s_tdata[rws_pkg::FITNESS_BITS-1:0];
	assign rnd      = s_tdata[rws_pkg::FITNESS_BITS +: rws_pkg::RANDOM_BITS];

	assign full        = (lc_q == rws_pkg::CNT_BITS'(rws_pkg::MAX_POPULATION));
	assign load_we     = in_acc && (cmd == rws_pkg::CMD_LOAD) && !full;
	assign prefix_base = (lc_q == '0) ? '0 : total_q;
	assign prefix_new  = prefix_base + rws_pkg::PREFIX_BITS'(fit);

	// error priority: empty, wanted too large, zero total, round already done
	always_comb begin
		if (lc_q == '0) begin
			draw_err = rws_pkg::ERR_EMPTY;
		end else if (pw_q > lc_q) begin
			draw_err = rws_pkg::ERR_WANTED;
		end else if (total_q == '0) begin
			draw_err = rws_pkg::ERR_ZERO;
		end else if (cc_q >= pw_q) begin
			draw_err = rws_pkg::ERR_DONE;
		end else begin
			draw_err = rws_pkg::ERR_OK;
		end
	end

	assign prod       = rws_pkg::PROD_BITS'(r_q) * rws_pkg::PROD_BITS'(total_q);
	// an entry is marked only if it carries the tag of the current round
	assign fresh      = (mark_rdata != epoch_q);
	assign cc_next    = cc_q + rws_pkg::CNT_BITS'(fresh);
	assign out_free   = !m_tvalid_q || m_tready;
	assign epoch_wrap = (epoch_q == '1);

	assign srch_start = (state_q == ST_MUL);
	assign last_idx   = rws_pkg::IDX_BITS'(lc_q - rws_pkg::CNT_BITS'(1));
	assign ram_addr   = load_we ? lc_q[rws_pkg::IDX_BITS-1:0] : srch_addr;

	rws_ram #(
		.WIDTH(rws_pkg::PREFIX_BITS),
		.DEPTH(rws_pkg::MAX_POPULATION)
	) u_prefix_ram (
		.clk  (clk),
		.we   (load_we),
		.addr (ram_addr),
		.wdata(prefix_new),
		.rdata(ram_rdata)
	);

	// mark read is issued on the last search cycle so the tag is ready in ST_MARK
	assign mark_we    = (state_q == ST_WIPE) || ((state_q == ST_MARK) && fresh);
	assign mark_addr  = (state_q == ST_WIPE) ? wipe_q :
		((state_q == ST_SEARCH) ? srch_stat.idx : idx_q);
	assign mark_wdata = (state_q == ST_WIPE) ? '0 : epoch_q;

	rws_ram #(
		.WIDTH(rws_pkg::EPOCH_BITS),
		.DEPTH(rws_pkg::MAX_POPULATION)
	) u_mark_ram (
		.clk  (clk),
		.we   (mark_we),
		.addr (mark_addr),
		.wdata(mark_wdata),
		.rdata(mark_rdata)
	);

	rws_search u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (srch_start),
		.last_idx(last_idx),
		.target  (target_q),
		.rd_data (ram_rdata),
		.rd_addr (srch_addr),
		.stat    (srch_stat)
	);

	// config port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready &&
		(paddr[2] == rws_pkg::REG_PARENTS_WANTED);
	assign prdata = (paddr[2] == rws_pkg::REG_PARENTS_WANTED) ?
		rws_pkg::CFG_DATA_BITS'(pw_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_q <= '0;
		end else if (cfg_we) begin
			pw_q <= pwdata[rws_pkg::CNT_BITS-1:0];
		end
	end

	// sequencer, counters, round tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WIPE;
			lc_q    <= '0;
			cc_q    <= '0;
			epoch_q <= rws_pkg::EPOCH_BITS'(1);
			wipe_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (cmd)
							rws_pkg::CMD_LOAD: begin
								if (!full) begin
									lc_q <= lc_q + rws_pkg::CNT_BITS'(1);
								end
							end
							rws_pkg::CMD_DRAW: begin
								state_q <= (draw_err == rws_pkg::ERR_OK) ? ST_MUL : ST_EMIT;
							end
							rws_pkg::CMD_NEW_ROUND: begin
								cc_q <= '0;
								if (epoch_wrap) begin
									epoch_q <= rws_pkg::EPOCH_BITS'(1);
									state_q <= ST_WIPE;
								end else begin
									epoch_q <= epoch_q + rws_pkg::EPOCH_BITS'(1);
								end
							end
							rws_pkg::CMD_CLEAR: begin
								cc_q <= '0;
								lc_q <= '0;
								if (epoch_wrap) begin
									epoch_q <= rws_pkg::EPOCH_BITS'(1);
									state_q <= ST_WIPE;
								end else begin
									epoch_q <= epoch_q + rws_pkg::EPOCH_BITS'(1);
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_MUL: begin
					state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					if (srch_stat.done) begin
						state_q <= ST_MARK;
					end
				end
				ST_MARK: begin
					cc_q    <= cc_next;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WIPE: begin
					wipe_q <= wipe_q + rws_pkg::IDX_BITS'(1);
					if (wipe_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// draw datapath and output beat
	always_ff @(posedge clk) begin
		if (load_we) begin
			total_q <= prefix_new;
		end
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (cmd == rws_pkg::CMD_DRAW)) begin
					r_q     <= rnd;
					err_q   <= draw_err;
					idx_q   <= '0;
					fresh_q <= 1'b0;
					done_q  <= (draw_err == rws_pkg::ERR_DONE);
				end
			end
			ST_MUL: begin
				target_q <= prod[rws_pkg::RANDOM_BITS +: rws_pkg::PREFIX_BITS];
			end
			ST_SEARCH: begin
				if (srch_stat.done) begin
					idx_q <= srch_stat.idx;
				end
			end
			ST_MARK: begin
				fresh_q <= fresh;
				done_q  <= (cc_next >= pw_q);
			end
			ST_EMIT: begin
				if (out_free) begin
					out_idx_q   <= idx_q;
					out_fresh_q <= fresh_q;
					out_done_q  <= done_q;
					out_err_q   <= err_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = rws_pkg::OUT_TDATA_BITS'({out_err_q, out_done_q, out_fresh_q, out_idx_q});

	`RWS_ASSERT_SAME(a_epoch_live, 1'b1, epoch_q != '0)
	`RWS_ASSERT_SAME(a_count_within_loaded, 1'b1, cc_q <= lc_q)
	`RWS_ASSERT_SAME(a_err_zero_payload, m_tvalid_q && (out_err_q != rws_pkg::ERR_OK), (out_idx_q == '0) && !out_fresh_q)
	`RWS_ASSERT_NEXT(a_beat_held, m_tvalid_q && !m_tready, m_tvalid_q && $stable(m_tdata))
	`RWS_ASSERT_NEXT(a_mark_leads_to_emit, state_q == ST_MARK, state_q == ST_EMIT)

endmodule
